/* rtl/core/fppa_pkg.sv */
// package: widths, op and status codes, sequencer states for the page pool allocator
package fppa_pkg;
    localparam int MAX_PAGES = 256;
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int CNT_W = IDX_W + 1;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'd1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE = 2'd1,
        OP_CREATE = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_NO_FREE = 3'd2,
        ST_BAD_ADDR = 3'd3,
        ST_DOUBLE_FREE = 3'd4,
        ST_POOL_FULL = 3'd5,
        ST_FAULT = 3'd6
    } t_status;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_RUN = 8'b0000_0100,
        S_FILL = 8'b0000_1000,
        S_ARD = 8'b0001_0000,
        S_ADONE = 8'b0010_0000,
        S_FCHK = 8'b0100_0000,
        S_OUT = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        FN_DIV = 2'd0,
        FN_MUL = 2'd1
    } t_fn;

    // control from sequencer to shared unit
    typedef struct packed {
        logic start;
        t_fn fn;
    } t_alu_ctl;

    // status from shared unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;
endpackage

/* rtl/core/fixed_page_pool_allocator.sv */
// top level: page pool allocator with a free-index fifo, bitmap and shared arithmetic unit
//  channel | direction | handshake          | payload
//  s_axis  | in        | tvalid/tready      | tdata: op, address
//  m_axis  | out       | tvalid/tready      | tdata: status, page_address
//  cfg     | in        | i_cfg_we           | page_count, page_size
// alloc reads the queue, then runs a 9-step multiply of index by page size
// free runs a 32-step restoring divide in the shared unit, then a bitmap check
// create runs an overflow multiply, then fifo and bitmap fill one entry a cycle
// delete and ops rejected at decode go straight to output; s_axis_tready low while busy
// a result held on m_axis blocks the next transaction until taken; reset is synchronous
module fixed_page_pool_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [39:0]                       s_axis_tdata,  // op[1:0], address[33:2], zeros
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // status[2:0], page_address[34:3]
    input  logic                              i_cfg_we,
    input  logic [fppa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fppa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fppa_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cfg_count;
    logic [SIZE_W-1:0] r_cfg_size;
    logic r_ready;
    logic [IDX_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0] r_free_cnt, r_pages;
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_bytes;
    t_op r_op;
    logic [ADDR_W-1:0] r_addr;
    t_status r_st;
    logic [ADDR_W-1:0] r_paddr;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_n;
    logic [IDX_W-1:0] mem [MAX_PAGES];
    logic [IDX_W-1:0] r_rd;
    logic free_map [MAX_PAGES];
    logic r_map_rd;
    logic r_out_v;

    t_alu_ctl w_ctl;
    t_alu_sts w_sts;
    logic [31:0] w_a, w_acc;
    logic [16:0] w_b;
    logic [32:0] w_prod;
    logic [31:0] w_quot;
    logic [16:0] w_rem;
    logic [ADDR_W-1:0] w_off;
    logic w_fchk_hit;
    logic w_push;
    logic w_mem_we;
    logic [IDX_W-1:0] w_mem_wa, w_mem_wd;
    logic w_map_we, w_map_wd;
    logic [IDX_W-1:0] w_map_wa;

    fppa_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_a(w_a), .i_b(w_b),
        .i_acc(w_acc), .o_sts(w_sts), .o_prod(w_prod), .o_quot(w_quot), .o_rem(w_rem)
    );

    assign w_off = r_addr - r_base;
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {5'd0, r_paddr, r_st};

    // page index in range and at a page start
    assign w_fchk_hit = (w_quot < {{(32-CNT_W){1'b0}}, r_pages}) && (w_rem == '0);
    assign w_push = (r_state == S_FCHK) && w_fchk_hit && !r_map_rd;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) mem[w_mem_wa] <= w_mem_wd;
        r_rd <= mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) free_map[w_map_wa] <= w_map_wd;
        r_map_rd <= free_map[w_quot[IDX_W-1:0]];
    end

    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.fn = FN_MUL;
        w_a = 32'd0;
        w_b = r_bytes;
        w_acc = 32'd0;
        w_mem_we = 1'b0;
        w_mem_wa = r_fill[IDX_W-1:0];
        w_mem_wd = r_fill[IDX_W-1:0];
        w_map_we = 1'b0;
        w_map_wa = r_fill[IDX_W-1:0];
        w_map_wd = 1'b1;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_DECODE;
            S_DECODE: begin
                unique case (r_op)
                    OP_CREATE: begin
                        w_ctl.start = !r_ready && r_cfg_size != '0;
                        w_a = {{(32-CNT_W){1'b0}}, r_n};
                        w_b = r_cfg_size;
                        w_acc = r_addr;
                        n_state = w_ctl.start ? S_RUN : S_OUT;
                    end
                    OP_ALLOC: n_state = (r_ready && r_free_cnt != '0) ? S_ARD : S_OUT;
                    OP_FREE: begin
                        w_ctl.start = r_ready && r_free_cnt < r_pages && r_addr >= r_base;
                        w_ctl.fn = FN_DIV;
                        w_a = w_off;
                        n_state = w_ctl.start ? S_RUN : S_OUT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_ARD: begin
                w_ctl.start = 1'b1;
                w_a = {{(32-IDX_W){1'b0}}, r_rd};
                w_acc = r_base;
                w_map_we = 1'b1;
                w_map_wa = r_rd;
                w_map_wd = 1'b0;
                n_state = S_ADONE;
            end
            S_ADONE: if (w_sts.done) n_state = S_OUT;
            S_RUN: begin
                if (w_sts.done) begin
                    if (r_op == OP_FREE) n_state = S_FCHK;
                    else if (w_prod[32] && w_prod[31:0] != '0) n_state = S_OUT;
                    else n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_fill < r_n) begin
                    w_mem_we = 1'b1;
                    w_map_we = 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FCHK: begin
                n_state = S_OUT;
                if (w_push) begin
                    w_mem_we = 1'b1;
                    w_mem_wa = r_tail;
                    w_mem_wd = w_quot[IDX_W-1:0];
                    w_map_we = 1'b1;
                    w_map_wa = w_quot[IDX_W-1:0];
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg_count <= '0;
            r_cfg_size <= SIZE_W'(1);
            r_ready <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_free_cnt <= '0;
            r_pages <= '0;
            r_base <= '0;
            r_bytes <= SIZE_W'(1);
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PAGE_COUNT) r_cfg_count <= i_cfg_data[CNT_W-1:0];
                else if (i_cfg_idx == REG_PAGE_SIZE) r_cfg_size <= i_cfg_data;
            end
            if (r_state == S_OUT) r_out_v <= 1'b1;
            else if (m_axis_tready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op <= t_op'(s_axis_tdata[1:0]);
                        r_addr <= s_axis_tdata[33:2];
                        r_n <= (r_cfg_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                                 : r_cfg_count;
                        r_paddr <= '0;
                        r_fill <= '0;
                    end
                end
                S_DECODE: begin
                    unique case (r_op)
                        OP_CREATE: r_st <= ST_FAULT;
                        OP_ALLOC: r_st <= !r_ready ? ST_NOT_READY
                                        : (r_free_cnt == '0 ? ST_NO_FREE : ST_OK);
                        OP_FREE: r_st <= !r_ready ? ST_NOT_READY
                                       : (r_free_cnt >= r_pages ? ST_POOL_FULL : ST_BAD_ADDR);
                        default: begin
                            r_st <= r_ready ? ST_OK : ST_NOT_READY;
                            if (r_ready) begin
                                r_ready <= 1'b0;
                                r_free_cnt <= '0;
                                r_head <= '0;
                                r_tail <= '0;
                            end
                        end
                    endcase
                end
                S_ARD: begin
                    r_head <= r_head + 1'b1;
                    r_free_cnt <= r_free_cnt - 1'b1;
                end
                S_ADONE: if (w_sts.done) r_paddr <= w_prod[31:0];
                S_FILL: begin
                    if (r_fill < r_n) begin
                        r_fill <= r_fill + 1'b1;
                    end else begin
                        r_head <= '0;
                        r_tail <= r_n[IDX_W-1:0];
                        r_free_cnt <= r_n;
                        r_base <= r_addr;
                        r_pages <= r_n;
                        r_bytes <= r_cfg_size;
                        r_ready <= 1'b1;
                        r_st <= ST_OK;
                    end
                end
                S_FCHK: begin
                    if (w_fchk_hit) begin
                        if (r_map_rd) begin
                            r_st <= ST_DOUBLE_FREE;
                        end else begin
                            r_st <= ST_OK;
                            r_tail <= r_tail + 1'b1;
                            r_free_cnt <= r_free_cnt + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/core/fppa_alu.sv */
// shared shift-add unit: multiply-accumulate or restoring divide, one bit a cycle
module fppa_alu (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fppa_pkg::t_alu_ctl       i_ctl,
    input  logic [31:0]              i_a,
    input  logic [16:0]              i_b,
    input  logic [31:0]              i_acc,
    output fppa_pkg::t_alu_sts       o_sts,
    output logic [32:0]              o_prod,
    output logic [31:0]              o_quot,
    output logic [16:0]              o_rem
);
    import fppa_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic r_done, n_done;
    t_fn r_fn, n_fn;
    logic [32:0] r_acc, n_acc;
    logic [31:0] r_q, n_q;
    logic [17:0] r_r, n_r;
    logic [16:0] r_b, n_b;
    logic [17:0] w_trial;

    assign w_trial = {r_r[16:0], r_q[31]} - {1'b0, r_b};

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_fn = r_fn;
        n_acc = r_acc;
        n_q = r_q;
        n_r = r_r;
        n_b = r_b;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_fn = i_ctl.fn;
            n_b = i_b;
            n_cnt = '0;
            n_acc = {1'b0, i_acc};
            n_q = i_a;
            n_r = '0;
        end else if (r_busy) begin
            if (r_fn == FN_MUL) begin
                // multiplier bits in r_q, lsb first
                if (r_q[0]) begin
                    n_acc = r_acc + ({16'd0, r_b} << r_cnt[4:0]);
                end
                n_q = {1'b0, r_q[31:1]};
                if (r_cnt == DIV_CNT_W'(8)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                if (!w_trial[17]) begin
                    n_r = w_trial;
                    n_q = {r_q[30:0], 1'b1};
                end else begin
                    n_r = {r_r[16:0], r_q[31]};
                    n_q = {r_q[30:0], 1'b0};
                end
                if (r_cnt == DIV_CNT_W'(31)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_fn <= n_fn;
        r_acc <= n_acc;
        r_q <= n_q;
        r_r <= n_r;
        r_b <= n_b;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod = r_acc;
    assign o_quot = r_q;
    assign o_rem = r_r[16:0];
endmodule
